// File: design/shuffle_deck_engine_defines.svh
// Assertion macros shared by the shuffle deck engine RTL.
`ifndef SHUFFLE_DECK_ENGINE_DEFINES_SVH
`define SHUFFLE_DECK_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SDE_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("assertion failed");
`define SDE_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define SDE_ASSERT_ALWAYS(label, cond)
`define SDE_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

// File: design/sdeck_pkg.sv
// Shared types, codes and helpers of the shuffle deck engine.
package sdeck_pkg;

    localparam int DECK_DEPTH_DEF = 64;
    localparam int CARD_BITS_DEF  = 16;
    localparam int LFSR_BITS      = 32;
    localparam int CARD_ID_W      = 16;
    localparam int POS_W          = 6;
    localparam int COUNT_OUT_W    = 7;
    localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_DRAW    = 2'd1;
    localparam logic [1:0] CMD_SHUFFLE = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_POS   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DRAW_RD,
        S_SH_START,
        S_SH_DIV,
        S_SH_RDJ,
        S_SH_WRI,
        S_SH_WRJ,
        S_DONE
    } state_t;

    function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] v);
        logic [LFSR_BITS-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

// File: design/shuffle_deck_engine.sv
// Insert reads and rewrites each shifted entry before placing the card; draw reads the top card.
// Shuffle runs the 32-step serial remainder unit once per held card, and that unit dominates.
// One transaction is in work at a time; a finished result waits in the output register
// while the next transaction is accepted.
// Synchronous active-low reset clears the count and the state machine and loads the
// LFSR with 1; the deck memory is not cleared and needs no clearing pass.
module shuffle_deck_engine #(
    parameter int DECK_DEPTH = sdeck_pkg::DECK_DEPTH_DEF,
    parameter int CARD_BITS  = sdeck_pkg::CARD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,  // random_seed
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // command[1:0], card_id[17:2], position[23:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // drawn_card[15:0], card_valid[16],
                                      // deck_count[23:17], status[25:24], zero pad
);
    import sdeck_pkg::*;
    `include "shuffle_deck_engine_defines.svh"

    localparam int CW = $clog2(DECK_DEPTH + 1);
    localparam int AW = $clog2(DECK_DEPTH);

    logic [CARD_BITS-1:0] mem [DECK_DEPTH];

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [AW-1:0]        j_reg, j_next;
    logic [CARD_BITS-1:0] card_reg, card_next;
    logic [CARD_BITS-1:0] di_reg, di_next;
    logic [CARD_BITS-1:0] rd_data_reg;
    logic [LFSR_BITS-1:0] lfsr_reg, lfsr_next;
    logic [1:0]           status_reg, status_next;
    logic [CARD_BITS-1:0] drawn_reg, drawn_next;
    logic                 valid_reg, valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [31:0]          m_tdata_reg, m_tdata_next;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [CARD_BITS-1:0] mem_wd;

    logic                 div_start;
    logic                 div_done;
    logic [CW-1:0]        div_rem;
    logic [LFSR_BITS-1:0] lfsr_adv;

    logic [1:0]           in_cmd;
    logic [CARD_ID_W-1:0] in_card;
    logic [POS_W-1:0]     in_pos;
    logic [CW+POS_W-1:0]  pos_ext;
    logic [CW+POS_W-1:0]  cnt_ext;
    logic [CW:0]          j_sum;
    logic [CW+COUNT_OUT_W-1:0]   cnt_out_ext;
    logic [CARD_BITS+CARD_ID_W-1:0] drawn_ext;
    logic [CARD_BITS+CARD_ID_W-1:0] card_ext;

    assign in_cmd   = s_tdata[1:0];
    assign in_card  = s_tdata[17:2];
    assign in_pos   = s_tdata[23:18];
    assign pos_ext  = (CW + POS_W)'(in_pos);
    assign cnt_ext  = (CW + POS_W)'(count_reg);
    assign card_ext = (CARD_BITS + CARD_ID_W)'(in_card);
    assign lfsr_adv = lfsr_step(lfsr_reg);
    assign j_sum    = {1'b0, i_reg} + {1'b0, div_rem};
    assign cnt_out_ext = (CW + COUNT_OUT_W)'(count_reg);
    assign drawn_ext   = (CARD_BITS + CARD_ID_W)'(drawn_reg);

    sdeck_mod #(
        .CW(CW)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (lfsr_adv),
        .divisor   (count_reg - i_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        card_next     = card_reg;
        di_next       = di_reg;
        lfsr_next     = lfsr_reg;
        status_next   = status_reg;
        drawn_next    = drawn_reg;
        valid_next    = valid_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        mem_we        = 1'b0;
        mem_wa        = '0;
        mem_wd        = '0;
        div_start     = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    status_next = ST_OK;
                    drawn_next  = '0;
                    valid_next  = 1'b0;
                    card_next   = card_ext[CARD_BITS-1:0];
                    state_next  = S_DONE;
                    unique case (in_cmd)
                        CMD_INSERT: begin
                            if (count_reg == CW'(DECK_DEPTH)) begin
                                status_next = ST_FULL;
                            end else if (in_pos != '0 && pos_ext > cnt_ext) begin
                                status_next = ST_POS;
                            end else begin
                                pos_next   = (in_pos == '0) ? count_reg : pos_ext[CW-1:0];
                                k_next     = count_reg;
                                state_next = (in_pos == '0 || pos_ext == cnt_ext)
                                             ? S_INS_PUT : S_INS_RD;
                            end
                        end
                        CMD_DRAW: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                count_next = count_reg - 1'b1;
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_reg - 1'b1);
                                state_next = S_DRAW_RD;
                            end
                        end
                        CMD_SHUFFLE: begin
                            i_next = '0;
                            if (count_reg != '0) begin
                                state_next = S_SH_START;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                rd_en      = 1'b1;
                rd_addr    = AW'(k_reg - 1'b1);
                state_next = S_INS_WR;
            end
            S_INS_WR: begin
                mem_we     = 1'b1;
                mem_wa     = AW'(k_reg);
                mem_wd     = rd_data_reg;
                k_next     = k_reg - 1'b1;
                state_next = ((k_reg - 1'b1) > pos_reg) ? S_INS_RD : S_INS_PUT;
            end
            S_INS_PUT: begin
                mem_we     = 1'b1;
                mem_wa     = AW'(pos_reg);
                mem_wd     = card_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DRAW_RD: begin
                drawn_next = rd_data_reg;
                valid_next = 1'b1;
                state_next = S_DONE;
            end
            S_SH_START: begin
                lfsr_next  = lfsr_adv;
                div_start  = 1'b1;
                state_next = S_SH_DIV;
            end
            S_SH_DIV: begin
                if (div_done) begin
                    j_next     = AW'(j_sum);
                    rd_en      = 1'b1;
                    rd_addr    = AW'(i_reg);
                    state_next = S_SH_RDJ;
                end
            end
            S_SH_RDJ: begin
                di_next    = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = j_reg;
                state_next = S_SH_WRI;
            end
            S_SH_WRI: begin
                mem_we     = 1'b1;
                mem_wa     = AW'(i_reg);
                mem_wd     = rd_data_reg;
                state_next = S_SH_WRJ;
            end
            S_SH_WRJ: begin
                mem_we     = 1'b1;
                mem_wa     = j_reg;
                mem_wd     = di_reg;
                i_next     = i_reg + 1'b1;
                state_next = ((i_reg + 1'b1) == count_reg) ? S_DONE : S_SH_START;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'd0, status_reg, cnt_out_ext[COUNT_OUT_W-1:0],
                                     valid_reg, drawn_ext[CARD_ID_W-1:0]};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Users must write a seed only while idle (unchecked); zero locks the LFSR.
        if (cfg_wr_en) begin
            lfsr_next = (cfg_wr_data == '0) ? LFSR_BITS'(1) : cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            lfsr_reg     <= LFSR_BITS'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            lfsr_reg     <= lfsr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pos_reg     <= pos_next;
        k_reg       <= k_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        card_reg    <= card_next;
        di_reg      <= di_next;
        status_reg  <= status_next;
        drawn_reg   <= drawn_next;
        valid_reg   <= valid_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `SDE_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DECK_DEPTH))
    `SDE_ASSERT_ALWAYS(a_lfsr_nonzero, lfsr_reg != '0)
    `SDE_ASSERT_IMPLY(a_shift_above_pos, state_reg == S_INS_RD, k_reg > pos_reg)
    `SDE_ASSERT_IMPLY(a_swap_in_range, state_reg == S_SH_WRJ, CW'(j_reg) < count_reg)
    `SDE_ASSERT_IMPLY(a_card_means_ok, m_tvalid && m_tdata[16], m_tdata[25:24] == ST_OK)

endmodule

// File: design/sdeck_mod.sv
// Bit-serial remainder unit: 32-bit dividend modulo a narrow divisor.
module sdeck_mod #(
    parameter int CW = 7
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sdeck_pkg::LFSR_BITS-1:0] dividend,
    input  logic [CW-1:0]                 divisor,
    output logic                          done,
    output logic [CW-1:0]                 remainder
);
    import sdeck_pkg::*;

    localparam int CNT_W = $clog2(LFSR_BITS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [LFSR_BITS-1:0] dvd_reg, dvd_next;
    logic [CW-1:0]        dsr_reg, dsr_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [CW:0]          trial;
    logic [CW:0]          diff;

    // One quotient bit per cycle; the partial remainder stays below the divisor.
    always_comb begin
        trial     = {rem_reg, dvd_reg[LFSR_BITS-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = (trial >= {1'b0, dsr_reg}) ? diff[CW-1:0] : trial[CW-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(LFSR_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: tb/sv/shuffle_deck_checker.sv
// Watches both streams of the shuffle deck engine, predicts each result and compares it.
module shuffle_deck_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          fail_count,
    output int          pending_results
);
    import sdeck_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  deck_count;
        logic        card_valid;
        logic [15:0] drawn_card;
    } deck_result_t;

    logic [15:0] deck_model [64];
    int unsigned held_cards;
    logic [31:0] shuffle_lfsr;
    deck_result_t expected_results [$];

    assign pending_results = expected_results.size();

    function automatic logic [31:0] advance_lfsr(input logic [31:0] v);
        logic [31:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ 32'h8020_0003;
        end
        return s;
    endfunction

    task automatic apply_command(input logic [23:0] item);
        deck_result_t r;
        logic [1:0]  cmd;
        logic [15:0] card;
        int unsigned pos;
        int unsigned j;
        logic [15:0] t;
        cmd  = item[1:0];
        card = item[17:2];
        pos  = item[23:18];
        r = '0;
        if (cmd == CMD_INSERT) begin
            if (held_cards >= 64) begin
                r.status = ST_FULL;
            end else if (pos != 0 && pos > held_cards) begin
                r.status = ST_POS;
            end else begin
                if (pos == 0) begin
                    pos = held_cards;
                end
                for (int k = held_cards; k > pos; k--) begin
                    deck_model[k] = deck_model[k-1];
                end
                deck_model[pos] = card;
                held_cards++;
            end
        end else if (cmd == CMD_DRAW) begin
            if (held_cards == 0) begin
                r.status = ST_EMPTY;
            end else begin
                held_cards--;
                r.drawn_card = deck_model[held_cards];
                r.card_valid = 1'b1;
            end
        end else if (cmd == CMD_SHUFFLE) begin
            for (int unsigned i = 0; i < held_cards; i++) begin
                shuffle_lfsr = advance_lfsr(shuffle_lfsr);
                j = i + shuffle_lfsr % (held_cards - i);
                t = deck_model[i];
                deck_model[i] = deck_model[j];
                deck_model[j] = t;
            end
        end
        r.deck_count = held_cards[6:0];
        expected_results.push_back(r);
    endtask

    always @(posedge aclk) begin
        deck_result_t got, want;
        if (!aresetn) begin
            held_cards   = 0;
            shuffle_lfsr = 32'd1;
            fail_count   <= 0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                shuffle_lfsr = (cfg_wr_data == 0) ? 32'd1 : cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                apply_command(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[25:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got != want || m_tdata[31:26] != 0) begin
                        $display("%0t: mismatch card %h/%h valid %b/%b count %0d/%0d st %0d/%0d",
                            $time, want.drawn_card, got.drawn_card, want.card_valid,
                            got.card_valid, want.deck_count, got.deck_count,
                            want.status, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/tb_shuffle_deck_engine.sv
// Top of the shuffle deck engine testbench: clock, reset, stimulus and verdict.
module tb_shuffle_deck_engine;
    import sdeck_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending_results;
    bit          hold_off = 1'b0;
    int          held_est = 0;

    always #1 aclk = ~aclk;

    shuffle_deck_engine DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    shuffle_deck_checker deck_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    // Receiver stalls on its own pattern; a hold-off request blocks it for a long stretch.
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                for (n = 0; n < 400; n++) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_tready <= ($urandom_range(0, 3) != 0) || ($time % 3000 > 2000);
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] card,
                             input logic [5:0] pos);
        s_tdata  <= {pos, card, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (cmd == CMD_INSERT && held_est < 64 && (pos == 0 || pos <= held_est)) begin
            held_est++;
        end else if (cmd == CMD_DRAW && held_est > 0) begin
            held_est--;
        end
    endtask

    // Sender: bursts of random length and random gaps between them.
    task automatic paced_item(input logic [1:0] cmd, input logic [15:0] card,
                              input logic [5:0] pos);
        if ($urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        send_item(cmd, card, pos);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        cfg_wr_data <= seed;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [5:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 6'd0;
        if (r < 8 && held_est > 0) return 6'($urandom_range(1, held_est));
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic random_phase(input int count);
        int r;
        logic [1:0] cmd;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (held_est < 20) cmd = (r < 70) ? CMD_INSERT : (r < 88) ? CMD_DRAW
                                  : (r < 97) ? CMD_SHUFFLE : 2'd3;
            else cmd = (r < 45) ? CMD_INSERT : (r < 85) ? CMD_DRAW
                     : (r < 97) ? CMD_SHUFFLE : 2'd3;
            paced_item(cmd, 16'($urandom), pick_position());
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // Directed: empty deck cases, extremes, bad position, unused command.
        send_item(CMD_DRAW, 16'h0, 6'd0);
        send_item(CMD_SHUFFLE, 16'h0, 6'd0);
        send_item(CMD_INSERT, 16'h0000, 6'd1);
        send_item(CMD_INSERT, 16'h0000, 6'd0);
        send_item(CMD_INSERT, 16'hFFFF, 6'd0);
        send_item(CMD_INSERT, 16'hA5A5, 6'd1);
        send_item(CMD_INSERT, 16'h5A5A, 6'd3);
        send_item(CMD_INSERT, 16'h1234, 6'd63);
        send_item(2'd3, 16'hFFFF, 6'd63);
        send_item(CMD_SHUFFLE, 16'h0, 6'd0);
        send_item(CMD_DRAW, 16'h0, 6'd0);
        send_item(CMD_DRAW, 16'h0, 6'd0);
        // Fill the deck to full, try once more, then shuffle a full deck.
        write_seed(32'h0000_0000);
        while (held_est < 64) send_item(CMD_INSERT, 16'($urandom), pick_position());
        send_item(CMD_INSERT, 16'hBEEF, 6'd0);
        send_item(CMD_SHUFFLE, 16'h0, 6'd0);
        write_seed(32'hFFFF_FFFF);
        send_item(CMD_SHUFFLE, 16'h0, 6'd0);
        random_phase(300);
        write_seed(32'h0000_0001);
        hold_off = 1'b1;
        random_phase(600);
        write_seed(32'($urandom) | 32'd1);
        random_phase(500);
        write_seed(32'($urandom));
        random_phase(550);
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule
